/* hdl/ej_pkg.sv */
// ----------------------------------------------------------------------------
// ej_pkg
// Types, constants and helpers shared by the event journal modules.
// ----------------------------------------------------------------------------
package ej_pkg;

  localparam int unsigned DepthDefault = 64;

  localparam int unsigned ReasonHiW = 64;
  localparam int unsigned ReasonLoW = 56;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned BattW     = 8;
  localparam int unsigned DropW     = 16;

  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [DropW-1:0] DROP_MAX     = 16'hFFFF;
  localparam logic [8:0]       BATT_MAX     = 9'd100;
  localparam logic [BattW-1:0] BATT_UNKNOWN = 8'hFF;

  // one stored journal entry, as kept in the entry memory
  typedef struct packed {
    logic [ReasonHiW-1:0] reason_hi;
    logic [ReasonLoW-1:0] reason_lo;
    logic [TimeW-1:0]     stamp;
    logic [BattW-1:0]     batt;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // status of the word waiting at the memory read port
  typedef struct packed {
    logic pend;
    logic last;
    logic marker;
  } rd_stat_t;

  // map a reported percent to the stored code: outside 0..100 is unknown
  function automatic logic [BattW-1:0] batt_code(input logic [8:0] raw);
    logic [BattW-1:0] code;
    if (raw[8] || (raw > BATT_MAX)) begin
      code = BATT_UNKNOWN;
    end else begin
      code = raw[BattW-1:0];
    end
    return code;
  endfunction

endpackage

/* hdl/event_journal_drop_oldest_unit.sv */
// ----------------------------------------------------------------------------
// event_journal_drop_oldest_unit
// Bounded event journal that keeps the newest DEPTH events, dropping the
// oldest on overflow.
// ----------------------------------------------------------------------------
// Input words carry an operation: record, read or clear. Record and clear
// complete in the cycle they are accepted and emit nothing. A read emits
// every stored entry oldest first, each tagged with the saturating drop
// count, with last set on the final word; an empty journal with drops
// emits one marker word (entry_present low), and with no drops nothing.
// Entries live in one synchronous RAM; a read walks it one address a cycle
// and delivers each word via the RAM read register and the output register,
// one word per cycle while out_stall_i stays low.
// in_stall_o is high from read acceptance until the last word has left the
// RAM read port; record and clear words may follow each other every cycle.
// When the receiver stalls, the output register holds its word and the
// RAM read data holds the next, so the walk pauses without loss.
// Reset empties the journal and zeroes the drop count; no clearing pass is
// needed since only written slots are ever read.
// ----------------------------------------------------------------------------
module event_journal_drop_oldest_unit #(
  parameter int unsigned DEPTH = ej_pkg::DepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          operation_i,
  input  logic [63:0]         reason_first8_i,
  input  logic [55:0]         reason_last7_i,
  input  logic                clock_valid_i,
  input  logic [31:0]         unix_time_i,
  input  logic signed [8:0]   battery_percent_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                entry_present_o,
  output logic [63:0]         out_reason_first8_o,
  output logic [55:0]         out_reason_last7_o,
  output logic [31:0]         timestamp_o,
  output logic signed [7:0]   battery_level_o,
  output logic [15:0]         drop_count_o,
  output logic                last_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                     we;
  logic [AW-1:0]            waddr;
  ej_pkg::entry_t           wdata;
  logic                     re;
  logic [AW-1:0]            raddr;
  logic [ej_pkg::EntryW-1:0] rdata;
  ej_pkg::entry_t           rd_entry;
  ej_pkg::rd_stat_t         rd_stat;
  logic [ej_pkg::DropW-1:0] drops;
  logic                     load;
  logic                     out_valid_q, out_valid_d;

  ej_journal #(
    .DEPTH(DEPTH)
  ) u_journal (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .reason_first8_i  (reason_first8_i),
    .reason_last7_i   (reason_last7_i),
    .clock_valid_i    (clock_valid_i),
    .unix_time_i      (unix_time_i),
    .battery_percent_i(battery_percent_i),
    .we_o             (we),
    .waddr_o          (waddr),
    .wdata_o          (wdata),
    .re_o             (re),
    .raddr_o          (raddr),
    .rd_stat_o        (rd_stat),
    .load_i           (load),
    .drops_o          (drops)
  );

  ej_ram #(
    .WIDTH(ej_pkg::EntryW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rd_entry = ej_pkg::entry_t'(rdata);

  // move the pending word into the output register when it is free
  assign load = rd_stat.pend && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload: a marker word carries only the drop count
  always_ff @(posedge clk_i) begin
    if (load) begin
      entry_present_o     <= !rd_stat.marker;
      out_reason_first8_o <= rd_stat.marker ? '0 : rd_entry.reason_hi;
      out_reason_last7_o  <= rd_stat.marker ? '0 : rd_entry.reason_lo;
      timestamp_o         <= rd_stat.marker ? '0 : rd_entry.stamp;
      battery_level_o     <= rd_stat.marker ? '0 : signed'(rd_entry.batt);
      drop_count_o        <= drops;
      last_o              <= rd_stat.last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* hdl/ej_ram.sv */
// ----------------------------------------------------------------------------
// ej_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ej_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/ej_journal.sv */
// ----------------------------------------------------------------------------
// ej_journal
// Ring pointers, entry count, drop counter and the read-out sequencer that
// drives the entry memory.
// ----------------------------------------------------------------------------
module ej_journal #(
  parameter int unsigned DEPTH = ej_pkg::DepthDefault,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                operation_i,
  input  logic [63:0]               reason_first8_i,
  input  logic [55:0]               reason_last7_i,
  input  logic                      clock_valid_i,
  input  logic [31:0]               unix_time_i,
  input  logic signed [8:0]         battery_percent_i,
  // memory side
  output logic                      we_o,
  output logic [AW-1:0]             waddr_o,
  output ej_pkg::entry_t            wdata_o,
  output logic                      re_o,
  output logic [AW-1:0]             raddr_o,
  // word at the read port and its hand-off to the output register
  output ej_pkg::rd_stat_t          rd_stat_o,
  input  logic                      load_i,
  output logic [ej_pkg::DropW-1:0]  drops_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 1;
  localparam logic [SW-1:0] DepthS = SW'(DEPTH);
  localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic                     state_q, state_d;
  logic [AW-1:0]            oldest_q, oldest_d;
  logic [CW-1:0]            count_q, count_d;
  logic [ej_pkg::DropW-1:0] drops_q, drops_d;
  logic [AW-1:0]            rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]            left_q, left_d;
  ej_pkg::rd_stat_t         stat_q, stat_d;

  logic          accept;
  logic          full;
  logic [SW-1:0] tail_sum;
  logic [AW-1:0] tail_slot;
  logic [AW-1:0] oldest_inc;
  logic [AW-1:0] rd_ptr_inc;
  logic          issue;

  assign in_stall_o = (state_q == ST_READ) || stat_q.pend;
  assign accept     = in_valid_i && !in_stall_o;

  assign full       = (count_q == DepthC);
  assign tail_sum   = SW'(oldest_q) + SW'(count_q);
  assign tail_slot  = (tail_sum >= DepthS) ? AW'(tail_sum - DepthS) : AW'(tail_sum);
  assign oldest_inc = (oldest_q == LastSlot) ? '0 : oldest_q + AW'(1);
  assign rd_ptr_inc = (rd_ptr_q == LastSlot) ? '0 : rd_ptr_q + AW'(1);

  // next read may go out once the word at the read port moves on
  assign issue = (state_q == ST_READ) && (!stat_q.pend || load_i);

  // record path: a full journal overwrites its oldest slot
  assign we_o              = accept && (operation_i == ej_pkg::OP_RECORD);
  assign waddr_o           = full ? oldest_q : tail_slot;
  assign wdata_o.reason_hi = reason_first8_i;
  assign wdata_o.reason_lo = reason_last7_i;
  assign wdata_o.stamp     = clock_valid_i ? unix_time_i : '0;
  assign wdata_o.batt      = ej_pkg::batt_code(battery_percent_i);

  assign re_o    = issue;
  assign raddr_o = rd_ptr_q;

  always_comb begin
    state_d  = state_q;
    oldest_d = oldest_q;
    count_d  = count_q;
    drops_d  = drops_q;
    rd_ptr_d = rd_ptr_q;
    left_d   = left_q;
    stat_d   = stat_q;

    if (load_i) begin
      stat_d.pend = 1'b0;
    end

    if (accept) begin
      unique case (operation_i)
        ej_pkg::OP_RECORD: begin
          if (full) begin
            oldest_d = oldest_inc;
            if (drops_q != ej_pkg::DROP_MAX) begin
              drops_d = drops_q + ej_pkg::DropW'(1);
            end
          end else begin
            count_d = count_q + CW'(1);
          end
        end
        ej_pkg::OP_READ: begin
          if (count_q != '0) begin
            state_d  = ST_READ;
            rd_ptr_d = oldest_q;
            left_d   = count_q;
          end else if (drops_q != '0) begin
            stat_d.pend   = 1'b1;
            stat_d.last   = 1'b1;
            stat_d.marker = 1'b1;
          end
        end
        ej_pkg::OP_CLEAR: begin
          oldest_d = '0;
          count_d  = '0;
          drops_d  = '0;
        end
        default: begin
        end
      endcase
    end

    if (issue) begin
      rd_ptr_d      = rd_ptr_inc;
      left_d        = left_q - CW'(1);
      stat_d.pend   = 1'b1;
      stat_d.last   = (left_q == CW'(1));
      stat_d.marker = 1'b0;
      if (left_q == CW'(1)) begin
        state_d = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      oldest_q <= '0;
      count_q  <= '0;
      drops_q  <= '0;
      rd_ptr_q <= '0;
      left_q   <= '0;
      stat_q   <= '0;
    end else begin
      state_q  <= state_d;
      oldest_q <= oldest_d;
      count_q  <= count_d;
      drops_q  <= drops_d;
      rd_ptr_q <= rd_ptr_d;
      left_q   <= left_d;
      stat_q   <= stat_d;
    end
  end

  assign rd_stat_o = stat_q;
  assign drops_o   = drops_q;

endmodule
